/* sv/kwm_pkg.sv */
`default_nettype none

package kwm_pkg;

    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 32;

    localparam logic [CFG_AW-1:0]  CFG_ADDR_LIST_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] LIST_COUNT_RESET    = 4'd8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MERGE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* sv/k_way_sorted_merge.sv */
// Channel  | Direction | Handshake               | Payload
// s_*      | in        | s_tvalid / s_tready     | s_tdata: list_index, value; s_tuser: operation
// m_*      | out       | m_tvalid / m_tready     | m_tdata: merged_value; m_tlast: last_of_run
// apb      | in        | psel, penable, pready   | register list_count at address 0
//
// A load item leaves the block in the idle state, so the block stays ready for more items.
// A merge item scans every list head through one comparator and one memory read
// port, one scan (states SCAN, LAST, DECIDE) per result, and a final scan
// finds the lists empty, flags the last result and clears all lists.
// The block accepts no item during a merge; a stalled output only holds the merge.
// Reset empties all lists and sets list_count to 8; no memory clearing pass runs.
`default_nettype none

module k_way_sorted_merge
    import kwm_pkg::*;
#(
    parameter int LISTS      = 8,
    parameter int LIST_DEPTH = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [2:0] list_index, [34:3] value, [39:35] zero
    input  wire logic [0:0]            s_tuser,   // [0] operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] merged_value
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_AW-1:0]     paddr,
    input  wire logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int LW        = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW        = $clog2(LIST_DEPTH + 1);
    localparam int AW        = LW + PW;
    localparam int MEM_DEPTH = LISTS * (1 << PW);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]        list_count_reg;
    logic [FW-1:0]             fill_reg [LISTS];
    logic [FW-1:0]             pos_reg [LISTS];
    logic signed [VALUE_W-1:0] mem_reg [MEM_DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic [LW-1:0]             i_reg;
    logic                      s1_valid_reg;
    logic                      s1_act_reg;
    logic [LW-1:0]             s1_idx_reg;
    logic [FW-1:0]             s1_pos_reg;
    logic                      best_found_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic [LW-1:0]             best_idx_reg;
    logic [FW-1:0]             best_pos_reg;
    logic                      pend_valid_reg;
    logic signed [VALUE_W-1:0] pend_val_reg;
    logic                      out_valid_reg;
    logic [VALUE_W-1:0]        out_val_reg;
    logic                      out_last_reg;

    logic                      load_fire;
    logic                      merge_fire;
    logic [IDX_W+1:0]          idx_ext;
    logic [LW-1:0]             load_list;
    logic                      load_go;
    logic [LW-1:0]             fill_addr;
    logic [FW-1:0]             fill_sel;
    logic [FW-1:0]             pos_sel;
    logic                      issue_act;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic                      cmp_take;
    logic                      out_free;
    logic                      decide_go;
    logic                      out_load;
    logic                      scan_start;
    logic                      cfg_write;
    logic                      fill_any;

    assign s_tready   = (state_reg == ST_IDLE);
    assign load_fire  = s_tvalid && s_tready && (s_tuser[0] == OP_LOAD);
    assign merge_fire = s_tvalid && s_tready && (s_tuser[0] == OP_MERGE);
    assign idx_ext    = {2'b00, s_tdata[IDX_W-1:0]};
    assign load_list  = idx_ext[LW-1:0];
    assign fill_addr  = (state_reg == ST_IDLE) ? load_list : i_reg;
    assign fill_sel   = fill_reg[fill_addr];
    assign pos_sel    = pos_reg[i_reg];
    assign load_go    = load_fire && (idx_ext < (IDX_W+2)'(LISTS))
                        && (fill_sel < FW'(LIST_DEPTH));
    assign issue_act  = ((COUNT_W+1)'(i_reg) < {1'b0, list_count_reg})
                        && (pos_sel < fill_sel);
    assign rd_addr    = {i_reg, pos_sel[PW-1:0]};
    assign wr_addr    = {load_list, fill_sel[PW-1:0]};
    assign cmp_take   = s1_valid_reg && s1_act_reg
                        && (!best_found_reg || (rdata_reg < best_val_reg));
    assign out_free   = !out_valid_reg || m_tready;
    assign decide_go  = (state_reg == ST_DECIDE) && (!pend_valid_reg || out_free);
    assign out_load   = decide_go && pend_valid_reg;
    assign scan_start = merge_fire || (decide_go && best_found_reg);
    assign cfg_write  = psel && penable && pwrite && pready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tlast  = out_last_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == CFG_ADDR_LIST_COUNT)
                      ? {{(CFG_DW-COUNT_W){1'b0}}, list_count_reg} : '0;

    always_comb
    begin
        fill_any = 1'b0;
        for (int k = 0; k < LISTS; k++)
        begin
            fill_any = fill_any | (fill_reg[k] != '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (merge_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (i_reg == LW'(LISTS - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    state_next = best_found_reg ? ST_SCAN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            list_count_reg <= LIST_COUNT_RESET;
            i_reg          <= '0;
            s1_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < LISTS; k++)
            begin
                fill_reg[k] <= '0;
                pos_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == ST_SCAN);

            if (cfg_write && (paddr == CFG_ADDR_LIST_COUNT))
            begin
                list_count_reg <= pwdata[COUNT_W-1:0];
            end

            if (load_go)
            begin
                fill_reg[load_list] <= fill_sel + FW'(1);
            end

            if (scan_start || (state_reg != ST_SCAN) || (i_reg == LW'(LISTS - 1)))
            begin
                i_reg <= '0;
            end
            else
            begin
                i_reg <= i_reg + LW'(1);
            end

            if (scan_start)
            begin
                best_found_reg <= 1'b0;
            end
            else if (cmp_take)
            begin
                best_found_reg <= 1'b1;
            end

            if (merge_fire)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (decide_go)
            begin
                pend_valid_reg <= best_found_reg;
                if (best_found_reg)
                begin
                    pos_reg[best_idx_reg] <= best_pos_reg + FW'(1);
                end
                else
                begin
                    for (int k = 0; k < LISTS; k++)
                    begin
                        fill_reg[k] <= '0;
                        pos_reg[k]  <= '0;
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            mem_reg[wr_addr] <= s_tdata[IDX_W +: VALUE_W];
        end
        rdata_reg  <= mem_reg[rd_addr];
        s1_idx_reg <= i_reg;
        s1_act_reg <= issue_act;
        s1_pos_reg <= pos_sel;
        if (cmp_take)
        begin
            best_val_reg <= rdata_reg;
            best_idx_reg <= s1_idx_reg;
            best_pos_reg <= s1_pos_reg;
        end
        if (decide_go && best_found_reg)
        begin
            pend_val_reg <= best_val_reg;
        end
        if (out_load)
        begin
            out_val_reg  <= pend_val_reg;
            out_last_reg <= !best_found_reg;
        end
    end

    // The chosen head always belongs to a list that takes part in the merge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && best_found_reg)
            |-> ((COUNT_W+1)'(best_idx_reg) < {1'b0, list_count_reg}))
        else $error("merge picked a head outside the active lists");

    // A scan that finds no head ends the merge with every list empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (decide_go && !best_found_reg) |=> (!fill_any && state_reg == ST_IDLE))
        else $error("lists not cleared at the end of a merge");

    // A new result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output item overwritten before it was taken");

    // The last item of a merge comes only from the scan that found no head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && best_found_reg) |=> !m_tlast)
        else $error("last flag set while heads remain");

endmodule

`default_nettype wire
